>>> hdl/gort_pkg.sv
package gort_pkg;

  // Request codes carried on req_type
  localparam logic [1:0] REQ_DRAW   = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // Statistic start values: min starts high, max starts low
  localparam logic signed [16:0] DIFF_MIN_INIT = 17'sh0ffff;
  localparam logic signed [16:0] DIFF_MAX_INIT = 17'sh10000;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DRAW,
    S_SQ,
    S_SCAN,
    S_CLEAR,
    S_DONE
  } state_t;

  // One stored record; keys are only stored when non-negative
  typedef struct packed {
    logic [14:0]        anchor;
    logic [14:0]        key;
    logic signed [16:0] offset;
  } entry_t;

  // Commands from the sequencer to the statistics unit
  typedef struct packed {
    logic draw;
    logic clear;
    logic hit_inc;
    logic miss_inc;
  } stats_cmd_t;

  // Statistics as reported with each result
  typedef struct packed {
    logic [31:0]        draw_count;
    logic signed [47:0] diff_sum;
    logic [63:0]        diff_sum_sq;
    logic signed [16:0] diff_min;
    logic signed [16:0] diff_max;
    logic [31:0]        lookup_hits;
    logic [31:0]        lookup_misses;
    logic [31:0]        lifetime_draws;
  } stats_t;

endpackage

>>> hdl/gort_store.sv
module gort_store #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  gort_pkg::entry_t wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output gort_pkg::entry_t rd_data
);

  gort_pkg::entry_t mem [DEPTH];

  // Write one record
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one record into a registered output
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/gort_stats.sv
module gort_stats (
  input  logic                  clk,
  input  logic                  rst,
  input  gort_pkg::stats_cmd_t  cmd,
  input  logic signed [15:0]    glyph_y,
  input  logic signed [15:0]    slot_top,
  output gort_pkg::stats_t      stats
);

  logic signed [16:0] d;
  logic signed [33:0] prod;
  logic [31:0]        sq;
  logic               sq_pend;
  logic [31:0]        cnt_draw;
  logic signed [47:0] acc_sum;
  logic [63:0]        acc_sq;
  logic signed [16:0] min_d;
  logic signed [16:0] max_d;
  logic [31:0]        cnt_hit;
  logic [31:0]        cnt_miss;
  logic [31:0]        cnt_life;

  // Form the difference and its square
  assign d    = {glyph_y[15], glyph_y} - {slot_top[15], slot_top};
  assign prod = d * d;

  // Register the square before it is accumulated
  always_ff @(posedge clk) begin
    if (cmd.draw) begin
      sq <= prod[31:0];
    end
  end

  // Update counters and running statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_pend  <= 1'b0;
      cnt_draw <= '0;
      acc_sum  <= '0;
      acc_sq   <= '0;
      min_d    <= gort_pkg::DIFF_MIN_INIT;
      max_d    <= gort_pkg::DIFF_MAX_INIT;
      cnt_hit  <= '0;
      cnt_miss <= '0;
      cnt_life <= '0;
    end else begin
      sq_pend <= cmd.draw;
      if (sq_pend) begin
        acc_sq <= acc_sq + {32'd0, sq};
      end
      if (cmd.clear) begin
        cnt_draw <= '0;
        acc_sum  <= '0;
        acc_sq   <= '0;
        min_d    <= gort_pkg::DIFF_MIN_INIT;
        max_d    <= gort_pkg::DIFF_MAX_INIT;
        cnt_hit  <= '0;
        cnt_miss <= '0;
      end
      if (cmd.draw) begin
        cnt_draw <= cnt_draw + 32'd1;
        cnt_life <= cnt_life + 32'd1;
        acc_sum  <= acc_sum + {{31{d[16]}}, d};
        if (d < min_d) begin
          min_d <= d;
        end
        if (d > max_d) begin
          max_d <= d;
        end
      end
      if (cmd.hit_inc) begin
        cnt_hit <= cnt_hit + 32'd1;
      end
      if (cmd.miss_inc) begin
        cnt_miss <= cnt_miss + 32'd1;
      end
    end
  end

  // Report; min and max read as zero while no draws are counted
  always_comb begin
    stats.draw_count     = cnt_draw;
    stats.diff_sum       = acc_sum;
    stats.diff_sum_sq    = acc_sq;
    stats.diff_min       = (cnt_draw != 32'd0) ? min_d : 17'sd0;
    stats.diff_max       = (cnt_draw != 32'd0) ? max_d : 17'sd0;
    stats.lookup_hits    = cnt_hit;
    stats.lookup_misses  = cnt_miss;
    stats.lifetime_draws = cnt_life;
  end

endmodule

>>> hdl/gort_seq.sv
module gort_seq #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int CW    = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           req_type,
  input  logic signed [15:0]   glyph_y,
  input  logic signed [15:0]   slot_top,
  input  logic signed [15:0]   col_anchor,
  input  logic signed [15:0]   slot_key,
  input  logic signed [16:0]   fallback_offset,
  input  logic                 out_free,
  output logic                 done,
  output logic signed [16:0]   found,
  output logic                 hit,
  output logic [CW-1:0]        fill,
  output logic signed [15:0]   cur_glyph_y,
  output logic signed [15:0]   cur_slot_top,
  output gort_pkg::stats_cmd_t cmd,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output gort_pkg::entry_t     wr_data,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr,
  input  gort_pkg::entry_t     rd_data
);

  gort_pkg::state_t   state;
  gort_pkg::state_t   state_next;
  logic               accept;
  logic signed [15:0] cur_anchor;
  logic signed [15:0] cur_key;
  logic signed [16:0] cur_fallback;
  logic [CW-1:0]      idx;
  logic               rd_valid;
  logic               match;
  logic               scan_end;
  logic               can_store;

  assign accept = in_valid && in_ready;

  // Compare the record returned by the read against the lookup key
  assign match = rd_valid && !cur_anchor[15] && !cur_key[15]
                 && (rd_data.anchor == cur_anchor[14:0])
                 && (rd_data.key == cur_key[14:0]);
  assign scan_end  = match || (idx >= fill);
  assign can_store = !cur_anchor[15] && !cur_key[15] && (fill < CW'(DEPTH));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      gort_pkg::S_IDLE: begin
        if (accept) begin
          unique case (req_type)
            gort_pkg::REQ_DRAW:   state_next = gort_pkg::S_DRAW;
            gort_pkg::REQ_LOOKUP: state_next = gort_pkg::S_SCAN;
            gort_pkg::REQ_CLEAR:  state_next = gort_pkg::S_CLEAR;
            default:              state_next = gort_pkg::S_DONE;
          endcase
        end
      end
      gort_pkg::S_DRAW:  state_next = gort_pkg::S_SQ;
      gort_pkg::S_SQ:    state_next = gort_pkg::S_DONE;
      gort_pkg::S_CLEAR: state_next = gort_pkg::S_DONE;
      gort_pkg::S_SCAN: begin
        if (scan_end) begin
          state_next = gort_pkg::S_DONE;
        end
      end
      gort_pkg::S_DONE: begin
        if (out_free) begin
          state_next = gort_pkg::S_IDLE;
        end
      end
      default: state_next = gort_pkg::S_IDLE;
    endcase
  end

  // Outputs per state
  always_comb begin
    in_ready     = (state == gort_pkg::S_IDLE);
    done         = (state == gort_pkg::S_DONE) && out_free;
    cmd.draw     = (state == gort_pkg::S_DRAW);
    cmd.clear    = (state == gort_pkg::S_CLEAR);
    cmd.hit_inc  = (state == gort_pkg::S_SCAN) && match;
    cmd.miss_inc = (state == gort_pkg::S_SCAN) && !match && (idx >= fill);
    wr_en        = (state == gort_pkg::S_DRAW) && can_store;
    rd_en        = (state == gort_pkg::S_SCAN) && !scan_end;
  end

  assign wr_addr        = fill[AW-1:0];
  assign rd_addr        = idx[AW-1:0];
  assign wr_data.anchor = cur_anchor[14:0];
  assign wr_data.key    = cur_key[14:0];
  assign wr_data.offset = {cur_glyph_y[15], cur_glyph_y} - {cur_key[15], cur_key};

  // Hold the request while it is worked on
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_glyph_y  <= glyph_y;
      cur_slot_top <= slot_top;
      cur_anchor   <= col_anchor;
      cur_key      <= slot_key;
      cur_fallback <= fallback_offset;
    end
  end

  // Advance state, scan pointer, table fill and lookup answer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= gort_pkg::S_IDLE;
      fill     <= '0;
      idx      <= '0;
      rd_valid <= 1'b0;
      found    <= '0;
      hit      <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= rd_en;
      if (accept) begin
        idx   <= '0;
        found <= '0;
        hit   <= 1'b0;
      end
      if (rd_en) begin
        idx <= idx + CW'(1);
      end
      if (wr_en) begin
        fill <= fill + CW'(1);
      end
      if (cmd.clear) begin
        fill <= '0;
      end
      if ((state == gort_pkg::S_SCAN) && scan_end) begin
        hit   <= match;
        found <= match ? rd_data.offset : cur_fallback;
      end
    end
  end

endmodule

>>> hdl/glyph_offset_record_table_unit.sv
// Channel | Handshake          | Payload
// request | in_valid/in_ready  | req_type glyph_y slot_top col_anchor slot_key fallback_offset
// result  | out_valid/out_ready| lookup_offset hit draw_count .. lifetime_draws
//
// One request at a time. A draw passes through the DRAW and SQ states, a clear through CLEAR
// and an unused code goes straight to DONE. A lookup stays in SCAN, the single read port of
// the record memory scanning one entry per cycle, until a match or the end of the table.
// Reset clears counters, statistics and table fill; no memory clearing pass.
// A result waiting on out_ready does not block accepting the next request; the
// request after it is held in its final state until the output register frees.
module glyph_offset_record_table_unit #(
  parameter int TABLE_DEPTH = 2048
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic signed [15:0] glyph_y,
  input  logic signed [15:0] slot_top,
  input  logic signed [15:0] col_anchor,
  input  logic signed [15:0] slot_key,
  input  logic signed [16:0] fallback_offset,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] lookup_offset,
  output logic               hit,
  output logic [31:0]        draw_count,
  output logic signed [47:0] diff_sum,
  output logic [63:0]        diff_sum_sq,
  output logic signed [16:0] diff_min,
  output logic signed [16:0] diff_max,
  output logic [11:0]        record_count,
  output logic [31:0]        lookup_hits,
  output logic [31:0]        lookup_misses,
  output logic [31:0]        lifetime_draws
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic                 out_free;
  logic                 done;
  logic signed [16:0]   found;
  logic                 hit_now;
  logic [CW-1:0]        fill;
  logic signed [15:0]   cur_glyph_y;
  logic signed [15:0]   cur_slot_top;
  gort_pkg::stats_cmd_t cmd;
  gort_pkg::stats_t     stats;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  gort_pkg::entry_t     wr_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  gort_pkg::entry_t     rd_data;

  assign out_free = !out_valid || out_ready;

  gort_seq #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_seq (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .req_type        (req_type),
    .glyph_y         (glyph_y),
    .slot_top        (slot_top),
    .col_anchor      (col_anchor),
    .slot_key        (slot_key),
    .fallback_offset (fallback_offset),
    .out_free        (out_free),
    .done            (done),
    .found           (found),
    .hit             (hit_now),
    .fill            (fill),
    .cur_glyph_y     (cur_glyph_y),
    .cur_slot_top    (cur_slot_top),
    .cmd             (cmd),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data)
  );

  gort_store #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  gort_stats u_stats (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .glyph_y  (cur_glyph_y),
    .slot_top (cur_slot_top),
    .stats    (stats)
  );

  // Track the output register's valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load the result when the request finishes
  always_ff @(posedge clk) begin
    if (done) begin
      lookup_offset  <= found;
      hit            <= hit_now;
      draw_count     <= stats.draw_count;
      diff_sum       <= stats.diff_sum;
      diff_sum_sq    <= stats.diff_sum_sq;
      diff_min       <= stats.diff_min;
      diff_max       <= stats.diff_max;
      record_count   <= 12'(fill);
      lookup_hits    <= stats.lookup_hits;
      lookup_misses  <= stats.lookup_misses;
      lifetime_draws <= stats.lifetime_draws;
    end
  end

endmodule

>>> hdl/gort_checker.sv
module gort_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [16:0] lookup_offset,
  input logic [31:0]        draw_count,
  input logic signed [16:0] diff_min,
  input logic signed [16:0] diff_max
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(lookup_offset) && $stable(draw_count))
    else $error("result changed while stalled");

  // Report zero extremes while no draws are counted
  a_empty_extremes: assert property (@(posedge clk) disable iff (rst)
    out_valid && (draw_count == 32'd0) |-> (diff_min == 17'sd0) && (diff_max == 17'sd0))
    else $error("min or max nonzero with zero draw count");

  // Keep min at or below max once draws are counted
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && (draw_count != 32'd0) |-> diff_min <= diff_max)
    else $error("min above max");

endmodule

bind glyph_offset_record_table_unit gort_checker u_gort_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .lookup_offset (lookup_offset),
  .draw_count    (draw_count),
  .diff_min      (diff_min),
  .diff_max      (diff_max)
);

>>> test/offset_table_checker.sv
`timescale 1ns / 1ps

module offset_table_checker #(
  parameter int TABLE_DEPTH = 2048
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic signed [15:0] glyph_y,
  input  logic signed [15:0] slot_top,
  input  logic signed [15:0] col_anchor,
  input  logic signed [15:0] slot_key,
  input  logic signed [16:0] fallback_offset,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [16:0] lookup_offset,
  input  logic               hit,
  input  logic [31:0]        draw_count,
  input  logic signed [47:0] diff_sum,
  input  logic [63:0]        diff_sum_sq,
  input  logic signed [16:0] diff_min,
  input  logic signed [16:0] diff_max,
  input  logic [11:0]        record_count,
  input  logic [31:0]        lookup_hits,
  input  logic [31:0]        lookup_misses,
  input  logic [31:0]        lifetime_draws,
  output int                 fail_count,
  output int                 outstanding
);

  typedef struct packed {
    logic signed [16:0] lookup_offset;
    logic               hit;
    logic [31:0]        draw_count;
    logic signed [47:0] diff_sum;
    logic [63:0]        diff_sum_sq;
    logic signed [16:0] diff_min;
    logic signed [16:0] diff_max;
    logic [11:0]        record_count;
    logic [31:0]        lookup_hits;
    logic [31:0]        lookup_misses;
    logic [31:0]        lifetime_draws;
  } table_result_t;

  // Shadow copy of the record table and the statistics
  logic signed [15:0] anchor_mem [TABLE_DEPTH];
  logic signed [15:0] key_mem    [TABLE_DEPTH];
  logic signed [16:0] offset_mem [TABLE_DEPTH];
  int                 fill;
  logic [31:0]        draws_r;
  logic signed [47:0] sum_r;
  logic [63:0]        sum_sq_r;
  logic signed [16:0] min_r;
  logic signed [16:0] max_r;
  logic [31:0]        hits_r;
  logic [31:0]        misses_r;
  logic [31:0]        lifetime_r;

  table_result_t expected_results[$];

  initial begin
    fail_count = 0;
    outstanding = 0;
  end

  // Drop the statistics, the table fill and the lookup counters
  function automatic void clear_stats();
    fill = 0;
    draws_r = '0;
    sum_r = '0;
    sum_sq_r = '0;
    min_r = gort_pkg::DIFF_MIN_INIT;
    max_r = gort_pkg::DIFF_MAX_INIT;
    hits_r = '0;
    misses_r = '0;
  endfunction

  // Apply one request to the shadow state and form the result it reports
  function automatic table_result_t apply_request(
    logic [1:0] req, logic signed [15:0] gy, logic signed [15:0] top,
    logic signed [15:0] anchor, logic signed [15:0] key, logic signed [16:0] fb
  );
    table_result_t res;
    logic signed [16:0] d;
    logic signed [63:0] sq;
    res = '0;
    case (req)
      gort_pkg::REQ_DRAW: begin
        d = gy - top;
        sq = d * d;
        draws_r = draws_r + 1;
        lifetime_r = lifetime_r + 1;
        sum_r = sum_r + d;
        sum_sq_r = sum_sq_r + sq;
        if (d < min_r) min_r = d;
        if (d > max_r) max_r = d;
        if (anchor >= 0 && key >= 0 && fill < TABLE_DEPTH) begin
          anchor_mem[fill] = anchor;
          key_mem[fill] = key;
          offset_mem[fill] = gy - key;
          fill++;
        end
      end
      gort_pkg::REQ_LOOKUP: begin
        res.lookup_offset = fb;
        for (int i = 0; i < fill; i++) begin
          if (!res.hit && anchor_mem[i] == anchor && key_mem[i] == key) begin
            res.lookup_offset = offset_mem[i];
            res.hit = 1'b1;
          end
        end
        if (res.hit) hits_r = hits_r + 1;
        else misses_r = misses_r + 1;
      end
      gort_pkg::REQ_CLEAR: clear_stats();
      default: ;
    endcase
    res.draw_count = draws_r;
    res.diff_sum = sum_r;
    res.diff_sum_sq = sum_sq_r;
    res.diff_min = (draws_r != 0) ? min_r : '0;
    res.diff_max = (draws_r != 0) ? max_r : '0;
    res.record_count = fill[11:0];
    res.lookup_hits = hits_r;
    res.lookup_misses = misses_r;
    res.lifetime_draws = lifetime_r;
    return res;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Compare each returned result, then queue the prediction for a new request
  always @(posedge clk) begin
    table_result_t want;
    if (rst) begin
      clear_stats();
      lifetime_r = '0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result returned with no request outstanding");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("lookup_offset", want.lookup_offset, lookup_offset);
          check_field("hit", want.hit, hit);
          check_field("draw_count", want.draw_count, draw_count);
          check_field("diff_sum", want.diff_sum, diff_sum);
          check_field("diff_sum_sq", want.diff_sum_sq, diff_sum_sq);
          check_field("diff_min", want.diff_min, diff_min);
          check_field("diff_max", want.diff_max, diff_max);
          check_field("record_count", want.record_count, record_count);
          check_field("lookup_hits", want.lookup_hits, lookup_hits);
          check_field("lookup_misses", want.lookup_misses, lookup_misses);
          check_field("lifetime_draws", want.lifetime_draws, lifetime_draws);
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_request(req_type, glyph_y, slot_top,
                                                 col_anchor, slot_key,
                                                 fallback_offset));
      end
    end
    outstanding = expected_results.size();
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int         DEPTH        = 2048;
  localparam int         RANDOM_ITEMS = 266;
  localparam int         CYCLE_LIMIT  = 1000000;
  localparam int         TAIL_CYCLES  = DEPTH + 50;
  localparam logic [1:0] REQ_UNUSED   = 2'd3;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         req_type = gort_pkg::REQ_DRAW;
  logic signed [15:0] glyph_y = '0;
  logic signed [15:0] slot_top = '0;
  logic signed [15:0] col_anchor = '0;
  logic signed [15:0] slot_key = '0;
  logic signed [16:0] fallback_offset = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [16:0] lookup_offset;
  logic               hit;
  logic [31:0]        draw_count;
  logic signed [47:0] diff_sum;
  logic [63:0]        diff_sum_sq;
  logic signed [16:0] diff_min;
  logic signed [16:0] diff_max;
  logic [11:0]        record_count;
  logic [31:0]        lookup_hits;
  logic [31:0]        lookup_misses;
  logic [31:0]        lifetime_draws;
  int                 fail_count;
  int                 outstanding;
  int                 cycle_count = 0;
  bit                 idle_on = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  glyph_offset_record_table_unit #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .glyph_y(glyph_y), .slot_top(slot_top),
    .col_anchor(col_anchor), .slot_key(slot_key),
    .fallback_offset(fallback_offset),
    .out_valid(out_valid), .out_ready(out_ready),
    .lookup_offset(lookup_offset), .hit(hit), .draw_count(draw_count),
    .diff_sum(diff_sum), .diff_sum_sq(diff_sum_sq),
    .diff_min(diff_min), .diff_max(diff_max), .record_count(record_count),
    .lookup_hits(lookup_hits), .lookup_misses(lookup_misses),
    .lifetime_draws(lifetime_draws)
  );

  offset_table_checker #(.TABLE_DEPTH(DEPTH)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .glyph_y(glyph_y), .slot_top(slot_top),
    .col_anchor(col_anchor), .slot_key(slot_key),
    .fallback_offset(fallback_offset),
    .out_valid(out_valid), .out_ready(out_ready),
    .lookup_offset(lookup_offset), .hit(hit), .draw_count(draw_count),
    .diff_sum(diff_sum), .diff_sum_sq(diff_sum_sq),
    .diff_min(diff_min), .diff_max(diff_max), .record_count(record_count),
    .lookup_hits(lookup_hits), .lookup_misses(lookup_misses),
    .lifetime_draws(lifetime_draws),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("glyph_offset_record_table_unit regression: fail");
      $finish;
    end
  end

  // Hold off, present one request and keep it until it is taken
  task automatic issue_request(logic [1:0] req, logic signed [15:0] gy,
                               logic signed [15:0] top, logic signed [15:0] anchor,
                               logic signed [15:0] key, logic signed [16:0] fb);
    int gap;
    bit took;
    gap = idle_on ? $urandom_range(12, 0) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    glyph_y <= gy;
    slot_top <= top;
    col_anchor <= anchor;
    slot_key <= key;
    fallback_offset <= fb;
    do begin
      @(posedge clk);
      took = in_ready;
    end while (!took);
    @(negedge clk);
  endtask

  // Keys small for a quarter so pairs repeat, at the extremes for a quarter, else random
  function automatic logic signed [15:0] draw_key();
    case ($urandom_range(3, 0))
      0: return 16'($urandom_range(7, 0));
      1: return $urandom_range(1, 0) ? 16'sd32767 : 16'sd0;
      default: return 16'($urandom_range(32767, 0));
    endcase
  endfunction

  // Stall the result side for a random number of cycles per result
  initial begin : result_sink
    int stall;
    while (rst) @(negedge clk);
    forever begin
      stall = idle_on ? $urandom_range(12, 0) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [31:0]        stored_pairs [$];
    logic [31:0]        pair;
    logic signed [15:0] anchor;
    logic signed [15:0] key;
    int                 pick;

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: extremes of the difference, skipped keys, first match wins
    issue_request(gort_pkg::REQ_LOOKUP, 0, 0, 0, 0, 17'sd65535);
    issue_request(gort_pkg::REQ_DRAW, 16'sd32767, -16'sd32768, 0, 0, 0);
    issue_request(gort_pkg::REQ_DRAW, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767, 0);
    issue_request(gort_pkg::REQ_DRAW, 16'sd5, 16'sd5, -16'sd1, 16'sd5, 0);
    issue_request(gort_pkg::REQ_DRAW, -16'sd9, 16'sd40, 16'sd5, -16'sd1, 0);
    issue_request(gort_pkg::REQ_DRAW, 16'sd77, -16'sd3, -16'sd1, -16'sd1, 0);
    issue_request(gort_pkg::REQ_DRAW, 16'sd100, 16'sd100, 0, 0, 0);
    issue_request(gort_pkg::REQ_LOOKUP, 0, 0, 0, 0, 17'sd123);
    issue_request(gort_pkg::REQ_LOOKUP, 0, 0, 16'sd32767, 16'sd32767, 17'sd1);
    issue_request(gort_pkg::REQ_LOOKUP, 0, 0, -16'sd1, 16'sd5, -17'sd65536);
    issue_request(gort_pkg::REQ_LOOKUP, 0, 0, 16'sd5, -16'sd1, 17'sd0);
    issue_request(gort_pkg::REQ_LOOKUP, 0, 0, 16'sd1, 16'sd1, -17'sd1);
    issue_request(REQ_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 17'($urandom));
    issue_request(gort_pkg::REQ_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 17'($urandom));
    issue_request(REQ_UNUSED, 16'sd1, 16'sd2, 16'sd3, 16'sd4, 17'sd5);
    issue_request(gort_pkg::REQ_LOOKUP, 0, 0, 0, 0, 17'sd4242);
    issue_request(gort_pkg::REQ_DRAW, 16'sd0, 16'sd0, 16'sd12, 16'sd34, 0);
    issue_request(gort_pkg::REQ_DRAW, -16'sd32768, -16'sd32768, 16'sd12, 16'sd34, 0);
    issue_request(gort_pkg::REQ_LOOKUP, 0, 0, 16'sd12, 16'sd34, 17'sd9);
    issue_request(gort_pkg::REQ_CLEAR, 0, 0, 0, 0, 0);

    // Record, look up, clear, then look up the dropped pair
    issue_request(gort_pkg::REQ_DRAW, 16'($urandom), 16'($urandom), 16'sd7, 16'sd7, 0);
    issue_request(gort_pkg::REQ_LOOKUP, 0, 0, 16'sd7, 16'sd7, 17'($urandom));
    issue_request(gort_pkg::REQ_CLEAR, 0, 0, 0, 0, 0);
    issue_request(gort_pkg::REQ_LOOKUP, 0, 0, 16'sd7, 16'sd7, 17'($urandom));

    // Random: mostly recorded draws and lookups of known pairs
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 32 == 0) idle_on = ($urandom_range(3, 0) != 0);
      pick = $urandom_range(99, 0);
      anchor = draw_key();
      key = draw_key();
      if (pick < 45) begin
        issue_request(gort_pkg::REQ_DRAW, 16'($urandom), 16'($urandom), anchor, key,
                      17'($urandom));
        stored_pairs.push_back({anchor, key});
      end else if (pick < 55) begin
        if ($urandom_range(1, 0)) anchor = -16'sd1;
        else key = -16'sd1;
        if ($urandom_range(3, 0) == 0) begin
          anchor = -16'sd1;
          key = -16'sd1;
        end
        issue_request(gort_pkg::REQ_DRAW, 16'($urandom), 16'($urandom), anchor, key,
                      17'($urandom));
      end else if (pick < 80 && stored_pairs.size() > 0) begin
        pair = stored_pairs[$urandom_range(stored_pairs.size() - 1, 0)];
        issue_request(gort_pkg::REQ_LOOKUP, 16'($urandom), 16'($urandom), pair[31:16],
                      pair[15:0], 17'($urandom));
      end else if (pick < 88) begin
        if ($urandom_range(4, 0) == 0) key = -16'sd1;
        issue_request(gort_pkg::REQ_LOOKUP, 16'($urandom), 16'($urandom), anchor, key,
                      17'($urandom));
      end else if (pick < 94) begin
        issue_request(gort_pkg::REQ_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 17'($urandom));
        stored_pairs.delete();
      end else begin
        issue_request(REQ_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 17'($urandom));
      end
    end
    in_valid <= 1'b0;

    // Drain, then watch for stray results
    while (outstanding != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("glyph_offset_record_table_unit regression: pass");
    end else begin
      $display("glyph_offset_record_table_unit regression: fail");
    end
    $finish;
  end

endmodule
